>>> hdl/dsa_pkg.sv
`default_nettype none
package dsa_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int PTR_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

  localparam int IDX_W     = 10;
  localparam int CAP_W     = 11;
  localparam int SIZE_W    = 13;
  localparam int ADDR_W    = 64;
  localparam int OFF_W     = SIZE_W + IDX_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;

  localparam logic [CAP_W-1:0]  CAPACITY_RST = CAP_W'(1024);
  localparam logic [SIZE_W-1:0] DESC_SIZE_RST = SIZE_W'(32);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_LIST_FULL = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY  = 2'd0,
    CFG_DESC_SIZE = 2'd1,
    CFG_CPU_BASE  = 2'd2,
    CFG_GPU_BASE  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ADD
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic mul;
    logic load;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

>>> hdl/dsa_req_if.sv
`default_nettype none
interface dsa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [dsa_pkg::IDX_W-1:0]  free_index;

  modport source (output valid, output req_type, output free_index, input ready);
  modport sink   (input valid, input req_type, input free_index, output ready);
endinterface
`default_nettype wire

>>> hdl/dsa_rsp_if.sv
`default_nettype none
interface dsa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [dsa_pkg::IDX_W-1:0]   slot_index;
  logic [dsa_pkg::ADDR_W-1:0]  cpu_address;
  logic [dsa_pkg::ADDR_W-1:0]  gpu_address;
  logic [1:0]                  status;

  modport source (output valid, output slot_index, output cpu_address,
                  output gpu_address, output status, input ready);
  modport sink   (input valid, input slot_index, input cpu_address,
                  input gpu_address, input status, output ready);
endinterface
`default_nettype wire

>>> hdl/dsa_cfg_if.sv
`default_nettype none
interface dsa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dsa_pkg::CFG_IDX_W-1:0]  index;
  logic [dsa_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/dsa_ram.sv
`default_nettype none
module dsa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/dsa_ctrl.sv
`default_nettype none
module dsa_ctrl (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output      logic       req_ready,
  input  wire logic       rsp_ready,
  output      logic       rsp_valid,
  output dsa_pkg::ctrl_cmd_t cmd
);

  dsa_pkg::ctrl_state_t state, state_next;
  logic                 rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dsa_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      dsa_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = dsa_pkg::S_MUL;
        end
      end
      dsa_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = dsa_pkg::S_ADD;
      end
      dsa_pkg::S_ADD: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load   = 1'b1;
          state_next = dsa_pkg::S_IDLE;
        end
      end
      default: state_next = dsa_pkg::S_IDLE;
    endcase

    if (cmd.load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule
`default_nettype wire

>>> hdl/dsa_datapath.sv
`default_nettype none
module dsa_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire dsa_pkg::ctrl_cmd_t              cmd,
  input  wire logic                            req_type,
  input  wire logic [dsa_pkg::IDX_W-1:0]       free_index,
  input  wire logic                            cfg_we,
  input  wire logic [dsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dsa_pkg::CFG_DAT_W-1:0]   cfg_data,
  output      logic [dsa_pkg::IDX_W-1:0]       slot_index,
  output      logic [dsa_pkg::ADDR_W-1:0]      cpu_address,
  output      logic [dsa_pkg::ADDR_W-1:0]      gpu_address,
  output      logic [1:0]                      status
);

  logic [dsa_pkg::CAP_W-1:0]  capacity;
  logic [dsa_pkg::SIZE_W-1:0] descriptor_size;
  logic [dsa_pkg::ADDR_W-1:0] cpu_base;
  logic [dsa_pkg::ADDR_W-1:0] gpu_base;

  logic [dsa_pkg::PTR_W-1:0]  free_head;
  logic [dsa_pkg::PTR_W-1:0]  free_tail;
  logic [dsa_pkg::CNT_W-1:0]  free_count;
  logic [dsa_pkg::CNT_W-1:0]  next_fresh;

  logic                       from_list;
  logic                       addr_valid;
  logic [dsa_pkg::IDX_W-1:0]  fresh_idx;
  dsa_pkg::status_t           status_r;
  logic [dsa_pkg::IDX_W-1:0]  idx_r;
  logic [dsa_pkg::OFF_W-1:0]  off_r;

  logic [dsa_pkg::CNT_W-1:0]  eff_cap;
  logic                       is_alloc;
  logic                       list_hit;
  logic                       fresh_ok;
  logic                       range_ok;
  logic                       list_room;
  logic                       pop;
  logic                       push;
  logic [dsa_pkg::IDX_W-1:0]  ram_rdata;
  logic [dsa_pkg::IDX_W-1:0]  idx_sel;
  dsa_pkg::status_t           status_new;

  function automatic logic [dsa_pkg::PTR_W-1:0] ptr_next(logic [dsa_pkg::PTR_W-1:0] p);
    return (p == dsa_pkg::PTR_W'(dsa_pkg::MAX_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    if (32'(capacity) > 32'(dsa_pkg::MAX_SLOTS)) begin
      eff_cap = dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS);
    end else begin
      eff_cap = dsa_pkg::CNT_W'(capacity);
    end
    is_alloc  = (req_type == dsa_pkg::REQ_ALLOC);
    list_hit  = (free_count != '0);
    fresh_ok  = (next_fresh < eff_cap);
    range_ok  = (dsa_pkg::CNT_W'(free_index) < eff_cap);
    list_room = (free_count < dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS));
    pop       = cmd.take && is_alloc && list_hit;
    push      = cmd.take && !is_alloc && range_ok && list_room;

    priority if (is_alloc && !list_hit && !fresh_ok) begin
      status_new = dsa_pkg::ST_FULL;
    end else if (!is_alloc && !range_ok) begin
      status_new = dsa_pkg::ST_RANGE;
    end else if (!is_alloc && !list_room) begin
      status_new = dsa_pkg::ST_LIST_FULL;
    end else begin
      status_new = dsa_pkg::ST_OK;
    end

    idx_sel = from_list ? ram_rdata : fresh_idx;
  end

  dsa_ram #(
    .WIDTH (dsa_pkg::IDX_W),
    .DEPTH (dsa_pkg::MAX_SLOTS)
  ) u_free_list (
    .clk   (clk),
    .we    (push),
    .waddr (free_tail),
    .wdata (free_index),
    .re    (pop),
    .raddr (free_head),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity        <= dsa_pkg::CAPACITY_RST;
      descriptor_size <= dsa_pkg::DESC_SIZE_RST;
      cpu_base        <= '0;
      gpu_base        <= '0;
      free_head       <= '0;
      free_tail       <= '0;
      free_count      <= '0;
      next_fresh      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (dsa_pkg::cfg_reg_t'(cfg_index))
          dsa_pkg::CFG_CAPACITY:  capacity        <= cfg_data[dsa_pkg::CAP_W-1:0];
          dsa_pkg::CFG_DESC_SIZE: descriptor_size <= cfg_data[dsa_pkg::SIZE_W-1:0];
          dsa_pkg::CFG_CPU_BASE:  cpu_base        <= cfg_data[dsa_pkg::ADDR_W-1:0];
          dsa_pkg::CFG_GPU_BASE:  gpu_base        <= cfg_data[dsa_pkg::ADDR_W-1:0];
          default: ;
        endcase
      end
      if (pop) begin
        free_head  <= ptr_next(free_head);
        free_count <= free_count - 1'b1;
      end else if (push) begin
        free_tail  <= ptr_next(free_tail);
        free_count <= free_count + 1'b1;
      end
      if (cmd.take && is_alloc && !list_hit && fresh_ok) begin
        next_fresh <= next_fresh + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      from_list  <= list_hit;
      fresh_idx  <= next_fresh[dsa_pkg::IDX_W-1:0];
      status_r   <= status_new;
      addr_valid <= is_alloc && (status_new == dsa_pkg::ST_OK);
    end
    if (cmd.mul) begin
      idx_r <= addr_valid ? idx_sel : '0;
      off_r <= addr_valid ? descriptor_size * idx_sel : '0;
    end
    if (cmd.load) begin
      slot_index  <= idx_r;
      cpu_address <= addr_valid ? cpu_base + dsa_pkg::ADDR_W'(off_r) : '0;
      gpu_address <= addr_valid ? gpu_base + dsa_pkg::ADDR_W'(off_r) : '0;
      status      <= status_r;
    end
  end

endmodule
`default_nettype wire

>>> hdl/descriptor_slot_allocator.sv
// Channel  Role    Word
// req      sink    req_type, free_index
// rsp      source  slot_index, cpu_address, gpu_address, status
// cfg      sink    index, data (capacity, descriptor_size, cpu_base, gpu_base)
//
// Each request passes through three steps: accept with the free-list read or write,
// the size-by-index product, then the two base additions.
// The result register lets the next request be accepted while a result waits.
// Reset is synchronous; the free-list RAM is not cleared and needs no sweep.
// A stalled result holds the final stage until the response is taken.
`default_nettype none
module descriptor_slot_allocator (
  input wire logic clk,
  input wire logic rst,
  dsa_req_if.sink   req,
  dsa_rsp_if.source rsp,
  dsa_cfg_if.sink   cfg
);

  dsa_pkg::ctrl_cmd_t cmd;

  assign cfg.ready = 1'b1;

  dsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .cmd       (cmd)
  );

  dsa_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_type    (req.req_type),
    .free_index  (req.free_index),
    .cfg_we      (cfg.valid && cfg.ready),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .slot_index  (rsp.slot_index),
    .cpu_address (rsp.cpu_address),
    .gpu_address (rsp.gpu_address),
    .status      (rsp.status)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while a previous one is in flight");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != dsa_pkg::ST_OK)) |->
      (rsp.slot_index == '0 && rsp.cpu_address == '0 && rsp.gpu_address == '0))
    else $error("erroneous response carries a nonzero index or address");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=>
      (rsp.valid && $stable(rsp.slot_index) && $stable(rsp.cpu_address) &&
       $stable(rsp.gpu_address) && $stable(rsp.status)))
    else $error("result word changed while stalled");
`endif

endmodule
`default_nettype wire

>>> sim/slot_grant_checker.sv
`default_nettype none
module slot_grant_checker
  import dsa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  dsa_req_if        req,
  dsa_rsp_if        rsp,
  dsa_cfg_if        cfg,
  output int        pending,
  output int        mismatches,
  output int        matched
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0]  slot_index;
    logic [ADDR_W-1:0] cpu_address;
    logic [ADDR_W-1:0] gpu_address;
    status_t           status;
  } slot_grant_t;

  slot_grant_t expected_grants[$];

  logic [IDX_W-1:0]  recycled [MAX_SLOTS];
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  wr_ptr;
  logic [CNT_W-1:0]  recycled_count;
  logic [CAP_W-1:0]  fresh_next;
  logic [CAP_W-1:0]  heap_capacity;
  logic [SIZE_W-1:0] slot_stride;
  logic [ADDR_W-1:0] cpu_origin;
  logic [ADDR_W-1:0] gpu_origin;

  slot_grant_t want;
  logic        bad;
  int          err_total;
  int          hit_total;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
    return (int'(ptr) == MAX_SLOTS - 1) ? '0 : ptr + 1'b1;
  endfunction

  function automatic slot_grant_t grant_request(input req_kind_t kind,
                                                input logic [IDX_W-1:0] idx);
    slot_grant_t       g;
    int                limit;
    logic [ADDR_W-1:0] offset;
    g = '0;
    g.status = ST_OK;
    limit = (int'(heap_capacity) > MAX_SLOTS) ? MAX_SLOTS : int'(heap_capacity);
    if (kind == REQ_ALLOC) begin
      if (recycled_count != '0) begin
        g.slot_index = recycled[rd_ptr];
        rd_ptr = advance(rd_ptr);
        recycled_count = recycled_count - 1'b1;
      end else if (int'(fresh_next) < limit) begin
        g.slot_index = fresh_next[IDX_W-1:0];
        fresh_next = fresh_next + 1'b1;
      end else begin
        g.status = ST_FULL;
      end
      if (g.status == ST_OK) begin
        offset = ADDR_W'(slot_stride) * ADDR_W'(g.slot_index);
        g.cpu_address = cpu_origin + offset;
        g.gpu_address = gpu_origin + offset;
      end
    end else begin
      if (int'(idx) >= limit) begin
        g.status = ST_RANGE;
      end else if (int'(recycled_count) >= MAX_SLOTS) begin
        g.status = ST_LIST_FULL;
      end else begin
        recycled[wr_ptr] = idx;
        wr_ptr = advance(wr_ptr);
        recycled_count = recycled_count + 1'b1;
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_grants.delete();
      rd_ptr = '0;
      wr_ptr = '0;
      recycled_count = '0;
      fresh_next = '0;
      heap_capacity = CAPACITY_RST;
      slot_stride = DESC_SIZE_RST;
      cpu_origin = '0;
      gpu_origin = '0;
      err_total = 0;
      hit_total = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_grants.size() == 0) begin
          $error("Unexpected result word: slot_index %0d, status %0d",
                 rsp.slot_index, rsp.status);
          err_total++;
        end else begin
          want = expected_grants.pop_front();
          bad = 1'b0;
          if (rsp.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, rsp.slot_index);
            bad = 1'b1;
          end
          if (rsp.cpu_address !== want.cpu_address) begin
            $error("cpu_address: expected %h, got %h", want.cpu_address, rsp.cpu_address);
            bad = 1'b1;
          end
          if (rsp.gpu_address !== want.gpu_address) begin
            $error("gpu_address: expected %h, got %h", want.gpu_address, rsp.gpu_address);
            bad = 1'b1;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            bad = 1'b1;
          end
          if (bad) begin
            err_total++;
          end else begin
            hit_total++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          CFG_CAPACITY:  heap_capacity = cfg.data[CAP_W-1:0];
          CFG_DESC_SIZE: slot_stride = cfg.data[SIZE_W-1:0];
          CFG_CPU_BASE:  cpu_origin = cfg.data;
          CFG_GPU_BASE:  gpu_origin = cfg.data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        expected_grants.push_back(grant_request(req_kind_t'(req.req_type), req.free_index));
      end
    end
    pending <= expected_grants.size();
    mismatches <= err_total;
    matched <= hit_total;
  end

endmodule
`default_nettype wire

>>> sim/descriptor_slot_allocator_tb.sv
`default_nettype none
module descriptor_slot_allocator_tb
  import dsa_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic steady = 1'b0;

  int pending;
  int mismatches;
  int matched;
  int sent = 0;
  int writes_done = 0;
  int cur_capacity = int'(CAPACITY_RST);
  int ready_hold;

  dsa_req_if req_ch ();
  dsa_rsp_if rsp_ch ();
  dsa_cfg_if cfg_ch ();

  descriptor_slot_allocator u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  slot_grant_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .pending    (pending),
    .mismatches (mismatches),
    .matched    (matched)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin : rsp_pacing
    int roll;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      ready_hold <= 0;
    end else if (steady) begin
      rsp_ch.ready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        rsp_ch.ready <= 1'b1;
        ready_hold <= $urandom_range(0, 8);
      end else if (roll < 95) begin
        rsp_ch.ready <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        rsp_ch.ready <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_base();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int pick_capacity();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 0;
    if (roll < 3) return 1;
    if (roll < 9) return $urandom_range(2, 16);
    if (roll < 13) return $urandom_range(17, 200);
    if (roll < 15) return $urandom_range(201, 1023);
    if (roll < 18) return MAX_SLOTS;
    return $urandom_range(1025, 2047);
  endfunction

  function automatic int pick_stride();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return 8191;
      3:       return 4096;
      default: return $urandom_range(1, 8191);
    endcase
  endfunction

  task automatic send_req(input req_kind_t kind, input logic [IDX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      req_ch.free_index <= IDX_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.free_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_cfg(input cfg_reg_t sel, input logic [CFG_DAT_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= sel;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (sel == CFG_CAPACITY) cur_capacity = int'(value[CAP_W-1:0]);
    writes_done++;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure_heap(input int cap, input int stride);
    logic [CFG_DAT_W-1:0] cap_word;
    cap_word = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) cap_word = '0;
    cap_word[CAP_W-1:0] = CAP_W'(cap);
    write_cfg(CFG_CAPACITY, cap_word);
    write_cfg(CFG_DESC_SIZE, CFG_DAT_W'(stride));
    write_cfg(CFG_CPU_BASE, pick_base());
    write_cfg(CFG_GPU_BASE, pick_base());
  endtask

  task automatic run_mix(input int count, input int alloc_pct);
    int               limit;
    logic [IDX_W-1:0] idx;
    limit = (cur_capacity > MAX_SLOTS) ? MAX_SLOTS : cur_capacity;
    repeat (count) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        send_req(REQ_ALLOC, IDX_W'($urandom));
      end else begin
        if (limit > 0 && $urandom_range(0, 99) < 85) begin
          idx = IDX_W'($urandom_range(0, limit - 1));
        end else begin
          idx = IDX_W'($urandom);
        end
        send_req(REQ_FREE, idx);
      end
    end
  endtask

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_ALLOC;
    req_ch.free_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_CAPACITY;
    cfg_ch.data = '0;
    rsp_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_FREE, IDX_W'(1023));
    send_req(REQ_FREE, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    wait_drained();

    // Addresses wrap past 2^64 and an oversized capacity is clamped.
    write_cfg(CFG_CPU_BASE, '1);
    write_cfg(CFG_GPU_BASE, 64'h8000_0000_0000_0000);
    write_cfg(CFG_DESC_SIZE, CFG_DAT_W'(8191));
    write_cfg(CFG_CAPACITY, '1);
    send_req(REQ_FREE, IDX_W'(1023));
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '1);
    wait_drained();

    write_cfg(CFG_CAPACITY, '0);
    write_cfg(CFG_DESC_SIZE, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_FREE, '0);
    send_req(REQ_FREE, IDX_W'(1023));
    wait_drained();

    write_cfg(CFG_CAPACITY, CFG_DAT_W'(3));
    send_req(REQ_ALLOC, '0);
    send_req(REQ_FREE, IDX_W'(2));
    send_req(REQ_ALLOC, '0);
    send_req(REQ_FREE, IDX_W'(3));
    wait_drained();

    write_cfg(CFG_CAPACITY, CFG_DAT_W'(5));
    write_cfg(CFG_DESC_SIZE, CFG_DAT_W'(4096));
    write_cfg(CFG_CPU_BASE, {$urandom, $urandom});
    write_cfg(CFG_GPU_BASE, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_FREE, IDX_W'(4));
    send_req(REQ_FREE, IDX_W'(1));
    send_req(REQ_FREE, IDX_W'(1));
    wait_drained();

    // Index 4 sits in the free list above the new capacity and is still handed out.
    write_cfg(CFG_CAPACITY, CFG_DAT_W'(2));
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       configure_heap(1, 1);
        1:       configure_heap(MAX_SLOTS, 4096);
        default: configure_heap(pick_capacity(), pick_stride());
      endcase
      steady = (p == 2) || ($urandom_range(0, 3) == 0);
      run_mix(100, $urandom_range(25, 75));
      wait_drained();
    end

    // Fill the free list to its limit so overflow and pointer wrap are reached.
    configure_heap(MAX_SLOTS, pick_stride());
    steady = 1'b1;
    repeat (MAX_SLOTS + 16) send_req(REQ_FREE, IDX_W'($urandom));
    steady = 1'b0;
    run_mix(60, 50);
    wait_drained();
    steady = 1'b1;
    run_mix(40, 60);
    wait_drained();

    repeat (10) @(posedge clk);
    $display("Run covered %0d requests and %0d register writes, %0d results matched,",
             sent, writes_done, matched);
    $display("including zero and clamped capacities and a free list filled past its limit.");
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> descriptor_slot_allocator.f
hdl/dsa_pkg.sv
hdl/dsa_req_if.sv
hdl/dsa_rsp_if.sv
hdl/dsa_cfg_if.sv
hdl/dsa_ram.sv
hdl/dsa_ctrl.sv
hdl/dsa_datapath.sv
hdl/descriptor_slot_allocator.sv
sim/slot_grant_checker.sv
sim/descriptor_slot_allocator_tb.sv
